// ===== design/lmpim_pkg.sv =====
`default_nettype none

package lmpim_pkg;

	localparam int MAX_PANEL_DIM = 64;
	localparam int MAX_TILES     = 16;

	localparam int FLAG_W     = 8;
	localparam int DIM_W      = 7;
	localparam int TILE_W     = 5;
	localparam int ROT_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int POS_W      = 16;
	localparam int COORD_W    = 10;
	localparam int SPAN_W     = 11;
	localparam int QUO_W      = 4;
	localparam int REM_W      = 6;
	localparam int TLINE_W    = 8;
	localparam int PIX_W      = 12;
	localparam int AREA_W     = 13;
	localparam int INDEX_W    = 20;

	// layout flag bit positions
	localparam int FLAG_PIX_BOTTOM  = 0;
	localparam int FLAG_PIX_RIGHT   = 1;
	localparam int FLAG_PIX_COLUMNS = 2;
	localparam int FLAG_PIX_ZIGZAG  = 3;
	localparam int FLAG_TILE_BOTTOM = 4;
	localparam int FLAG_TILE_RIGHT  = 5;
	localparam int FLAG_TILE_COLUMNS = 6;
	localparam int FLAG_TILE_ZIGZAG = 7;

	localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAYOUT   = 3'd0,
		REG_PANEL_W  = 3'd1,
		REG_PANEL_H  = 3'd2,
		REG_TILES_X  = 3'd3,
		REG_TILES_Y  = 3'd4,
		REG_ROTATION = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [FLAG_W-1:0] flags;
		logic [DIM_W-1:0]  panel_w;
		logic [DIM_W-1:0]  panel_h;
		logic [TILE_W-1:0] tiles_x;
		logic [TILE_W-1:0] tiles_y;
		logic [ROT_W-1:0]  rotation;
	} cfg_t;

	// unrotated display coordinate
	typedef struct packed {
		logic               in_range;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} coord_t;

	// coordinate split into panel number and pixel inside the panel
	typedef struct packed {
		logic             in_range;
		logic [QUO_W-1:0] tile_x;
		logic [QUO_W-1:0] tile_y;
		logic [REM_W-1:0] pix_x;
		logic [REM_W-1:0] pix_y;
	} split_t;

endpackage

`default_nettype wire

// ===== design/led_matrix_pixel_index_map_top.sv =====
`default_nettype none

// LED matrix pixel index map: screen coordinate in, strip position out.
//
// Input: drive pos_x/pos_y (signed) with start high; a word is taken at
// every clock edge with start high. busy is tied low, so one coordinate
// can enter every cycle and several are in flight at once.
// Output: done pulses for one cycle with in_range and led_index valid.
// Out-of-bounds points give in_range 0 and led_index 0. The receiver
// cannot stall; results must be taken as they appear.
// Throughput: 1 word per cycle, set by the five-stage pipe (bounds and
// rotation, two radix-2x2 divider stages for panel number, layout and
// line multiply, panel-offset multiply and add).
// Configuration: cfg_we/cfg_index/cfg_data write one register per edge
// (0 layout flags, 1 panel width, 2 panel height, 3 tiles across, 4 tiles
// down, 5 rotation). Panel sizes (low 7 data bits) saturate at 64, tile
// counts (low 5) at 16; other indexes are dropped. Write only while the pipe is empty.
// Reset: arst_n clears all in-flight words and loads the 8x8 single-panel,
// unrotated, progressive layout.
module led_matrix_pixel_index_map_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [lmpim_pkg::POS_W-1:0]        pos_x,
	input  wire logic [lmpim_pkg::POS_W-1:0]        pos_y,
	input  wire logic                               cfg_we,
	input  wire logic [lmpim_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lmpim_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                    done,
	output logic                                    in_range,
	output logic [lmpim_pkg::INDEX_W-1:0]           led_index
);

	lmpim_pkg::cfg_t                   cfg_q;
	logic                              valid_s1;
	lmpim_pkg::coord_t                 coord_s1;
	logic                              valid_s3;
	lmpim_pkg::split_t                 split_s3;
	logic [lmpim_pkg::DIM_W-1:0]       dim_sat;
	logic [lmpim_pkg::TILE_W-1:0]      tile_sat;

	// never stall the input side
	assign busy = 1'b0;

	// clamp oversize panel dimensions and tile counts on write
	assign dim_sat = (cfg_data[lmpim_pkg::DIM_W-1:0] > lmpim_pkg::DIM_W'(lmpim_pkg::MAX_PANEL_DIM))
		? lmpim_pkg::DIM_W'(lmpim_pkg::MAX_PANEL_DIM) : cfg_data[lmpim_pkg::DIM_W-1:0];
	assign tile_sat = (cfg_data[lmpim_pkg::TILE_W-1:0] > lmpim_pkg::TILE_W'(lmpim_pkg::MAX_TILES))
		? lmpim_pkg::TILE_W'(lmpim_pkg::MAX_TILES) : cfg_data[lmpim_pkg::TILE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flags    <= '0;
			cfg_q.panel_w  <= 7'd8;
			cfg_q.panel_h  <= 7'd8;
			cfg_q.tiles_x  <= '0;
			cfg_q.tiles_y  <= '0;
			cfg_q.rotation <= lmpim_pkg::ROT_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				lmpim_pkg::REG_LAYOUT:   cfg_q.flags    <= cfg_data;
				lmpim_pkg::REG_PANEL_W:  cfg_q.panel_w  <= dim_sat;
				lmpim_pkg::REG_PANEL_H:  cfg_q.panel_h  <= dim_sat;
				lmpim_pkg::REG_TILES_X:  cfg_q.tiles_x  <= tile_sat;
				lmpim_pkg::REG_TILES_Y:  cfg_q.tiles_y  <= tile_sat;
				lmpim_pkg::REG_ROTATION: cfg_q.rotation <= cfg_data[lmpim_pkg::ROT_W-1:0];
				default: ;
			endcase
		end
	end

	// bounds check and rotation
	lmpim_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.coord_s1 (coord_s1)
	);

	// split into panel number and pixel within the panel
	lmpim_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.coord_s1 (coord_s1),
		.cfg      (cfg_q),
		.valid_s3 (valid_s3),
		.split_s3 (split_s3)
	);

	// layout ordering and final strip index
	lmpim_index u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.split_s3    (split_s3),
		.cfg         (cfg_q),
		.valid_s5    (done),
		.in_range_s5 (in_range),
		.index_s5    (led_index)
	);

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result word without a coordinate five cycles earlier");

	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> led_index == '0)
		else $error("out-of-range word carries a nonzero index");

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> $past(valid_s1, 2))
		else $error("word appeared in the middle of the pipe");

endmodule

`default_nettype wire

// ===== design/lmpim_front.sv =====
`default_nettype none

module lmpim_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [lmpim_pkg::POS_W-1:0]    pos_x,
	input  wire logic [lmpim_pkg::POS_W-1:0]    pos_y,
	input  wire lmpim_pkg::cfg_t                cfg,
	output logic                                valid_s1,
	output lmpim_pkg::coord_t                   coord_s1
);

	logic                              tiled;
	logic [11:0]                       prod_w;
	logic [11:0]                       prod_h;
	logic [lmpim_pkg::SPAN_W-1:0]      full_w;
	logic [lmpim_pkg::SPAN_W-1:0]      full_h;
	logic [lmpim_pkg::SPAN_W-1:0]      lim_x;
	logic [lmpim_pkg::SPAN_W-1:0]      lim_y;
	logic                              in_bounds;
	logic [lmpim_pkg::COORD_W-1:0]     xn;
	logic [lmpim_pkg::COORD_W-1:0]     yn;
	logic [lmpim_pkg::SPAN_W-1:0]      w_minus_y;
	logic [lmpim_pkg::SPAN_W-1:0]      w_minus_x;
	logic [lmpim_pkg::SPAN_W-1:0]      h_minus_y;
	logic [lmpim_pkg::SPAN_W-1:0]      h_minus_x;
	lmpim_pkg::coord_t                 coord_d;

	assign tiled  = cfg.tiles_x != '0;
	assign prod_w = {5'b0, cfg.panel_w} * {7'b0, cfg.tiles_x};
	assign prod_h = {5'b0, cfg.panel_h} * {7'b0, cfg.tiles_y};
	assign full_w = tiled ? prod_w[lmpim_pkg::SPAN_W-1:0] : {4'b0, cfg.panel_w};
	assign full_h = tiled ? prod_h[lmpim_pkg::SPAN_W-1:0] : {4'b0, cfg.panel_h};
	assign lim_x  = cfg.rotation[0] ? full_h : full_w;
	assign lim_y  = cfg.rotation[0] ? full_w : full_h;

	assign in_bounds = !pos_x[15] && !pos_y[15]
		&& (pos_x[14:0] < {4'b0, lim_x}) && (pos_y[14:0] < {4'b0, lim_y});

	assign xn = pos_x[lmpim_pkg::COORD_W-1:0];
	assign yn = pos_y[lmpim_pkg::COORD_W-1:0];

	assign w_minus_y = full_w - 11'd1 - {1'b0, yn};
	assign w_minus_x = full_w - 11'd1 - {1'b0, xn};
	assign h_minus_y = full_h - 11'd1 - {1'b0, yn};
	assign h_minus_x = full_h - 11'd1 - {1'b0, xn};

	// turn the screen point back to the unrotated frame
	always_comb begin
		coord_d.in_range = in_bounds;
		case (cfg.rotation)
			lmpim_pkg::ROT_90: begin
				coord_d.x = w_minus_y[lmpim_pkg::COORD_W-1:0];
				coord_d.y = xn;
			end
			lmpim_pkg::ROT_180: begin
				coord_d.x = w_minus_x[lmpim_pkg::COORD_W-1:0];
				coord_d.y = h_minus_y[lmpim_pkg::COORD_W-1:0];
			end
			lmpim_pkg::ROT_270: begin
				coord_d.x = yn;
				coord_d.y = h_minus_x[lmpim_pkg::COORD_W-1:0];
			end
			default: begin
				coord_d.x = xn;
				coord_d.y = yn;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		coord_s1 <= coord_d;
	end

	a_range_needs_positive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && coord_s1.in_range |-> $past(!pos_x[15] && !pos_y[15]))
		else $error("in-range word came from a negative coordinate");

endmodule

`default_nettype wire

// ===== design/lmpim_div.sv =====
`default_nettype none

module lmpim_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s1,
	input  wire lmpim_pkg::coord_t   coord_s1,
	input  wire lmpim_pkg::cfg_t     cfg,
	output logic                     valid_s3,
	output lmpim_pkg::split_t        split_s3
);

	// one restoring step: {quotient bit, new remainder}
	function automatic logic [lmpim_pkg::COORD_W:0] div_step(
		input logic [lmpim_pkg::COORD_W-1:0] rem,
		input logic [lmpim_pkg::COORD_W-1:0] dsr
	);
		logic ge;
		ge = rem >= dsr;
		return {ge, ge ? rem - dsr : rem};
	endfunction

	logic                            valid_s2;
	logic                            in_range_s2;
	logic [1:0]                      qx_s2;
	logic [1:0]                      qy_s2;
	logic [lmpim_pkg::COORD_W-1:0]   remx_s2;
	logic [lmpim_pkg::COORD_W-1:0]   remy_s2;

	logic [lmpim_pkg::COORD_W:0]     sx3, sx2, sx1, sx0;
	logic [lmpim_pkg::COORD_W:0]     sy3, sy2, sy1, sy0;

	// upper two quotient bits
	assign sx3 = div_step(coord_s1.x, {cfg.panel_w, 3'b000});
	assign sx2 = div_step(sx3[lmpim_pkg::COORD_W-1:0], {1'b0, cfg.panel_w, 2'b00});
	assign sy3 = div_step(coord_s1.y, {cfg.panel_h, 3'b000});
	assign sy2 = div_step(sy3[lmpim_pkg::COORD_W-1:0], {1'b0, cfg.panel_h, 2'b00});

	// lower two quotient bits
	assign sx1 = div_step(remx_s2, {2'b00, cfg.panel_w, 1'b0});
	assign sx0 = div_step(sx1[lmpim_pkg::COORD_W-1:0], {3'b000, cfg.panel_w});
	assign sy1 = div_step(remy_s2, {2'b00, cfg.panel_h, 1'b0});
	assign sy0 = div_step(sy1[lmpim_pkg::COORD_W-1:0], {3'b000, cfg.panel_h});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		in_range_s2       <= coord_s1.in_range;
		qx_s2             <= {sx3[lmpim_pkg::COORD_W], sx2[lmpim_pkg::COORD_W]};
		qy_s2             <= {sy3[lmpim_pkg::COORD_W], sy2[lmpim_pkg::COORD_W]};
		remx_s2           <= sx2[lmpim_pkg::COORD_W-1:0];
		remy_s2           <= sy2[lmpim_pkg::COORD_W-1:0];
		split_s3.in_range <= in_range_s2;
		split_s3.tile_x   <= {qx_s2, sx1[lmpim_pkg::COORD_W], sx0[lmpim_pkg::COORD_W]};
		split_s3.tile_y   <= {qy_s2, sy1[lmpim_pkg::COORD_W], sy0[lmpim_pkg::COORD_W]};
		split_s3.pix_x    <= sx0[lmpim_pkg::REM_W-1:0];
		split_s3.pix_y    <= sy0[lmpim_pkg::REM_W-1:0];
	end

	a_valid_travels: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> $past(valid_s1, 2))
		else $error("divider output valid without an entering word");

endmodule

`default_nettype wire

// ===== design/lmpim_index.sv =====
`default_nettype none

module lmpim_index (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s3,
	input  wire lmpim_pkg::split_t             split_s3,
	input  wire lmpim_pkg::cfg_t               cfg,
	output logic                               valid_s5,
	output logic                               in_range_s5,
	output logic [lmpim_pkg::INDEX_W-1:0]      index_s5
);

	logic                              tiled;
	logic [lmpim_pkg::TILE_W-1:0]      tx, ty, tmaj, tmin, tscale, tmul;
	logic                              tzig;
	logic [9:0]                        tbase, tline_full;
	logic [lmpim_pkg::DIM_W-1:0]       px, py, pmaj, pmin, pscale, pmul;
	logic                              pzig;
	logic [13:0]                       pbase, pix_full, area_full;

	logic                              valid_s4;
	logic                              in_range_s4;
	logic [lmpim_pkg::TLINE_W-1:0]     tline_s4;
	logic [lmpim_pkg::PIX_W-1:0]       pix_s4;
	logic [lmpim_pkg::AREA_W-1:0]      area_s4;

	logic [20:0]                       tile_off;
	logic [20:0]                       sum;

	assign tiled = cfg.tiles_x != '0;

	// panel order inside the grid; the pixel corner is left alone on zigzag lines
	assign tx = cfg.flags[lmpim_pkg::FLAG_TILE_RIGHT]
		? cfg.tiles_x - 5'd1 - {1'b0, split_s3.tile_x} : {1'b0, split_s3.tile_x};
	assign ty = cfg.flags[lmpim_pkg::FLAG_TILE_BOTTOM]
		? cfg.tiles_y - 5'd1 - {1'b0, split_s3.tile_y} : {1'b0, split_s3.tile_y};
	assign tmaj   = cfg.flags[lmpim_pkg::FLAG_TILE_COLUMNS] ? tx : ty;
	assign tmin   = cfg.flags[lmpim_pkg::FLAG_TILE_COLUMNS] ? ty : tx;
	assign tscale = cfg.flags[lmpim_pkg::FLAG_TILE_COLUMNS] ? cfg.tiles_y : cfg.tiles_x;
	assign tzig   = cfg.flags[lmpim_pkg::FLAG_TILE_ZIGZAG] && tmaj[0];
	assign tmul   = tzig ? tmaj + 5'd1 : tmaj;
	assign tbase  = {5'b0, tmul} * {5'b0, tscale};
	assign tline_full = tzig ? tbase - 10'd1 - {5'b0, tmin} : tbase + {5'b0, tmin};

	// pixel order inside one panel
	assign px = cfg.flags[lmpim_pkg::FLAG_PIX_RIGHT]
		? cfg.panel_w - 7'd1 - {1'b0, split_s3.pix_x} : {1'b0, split_s3.pix_x};
	assign py = cfg.flags[lmpim_pkg::FLAG_PIX_BOTTOM]
		? cfg.panel_h - 7'd1 - {1'b0, split_s3.pix_y} : {1'b0, split_s3.pix_y};
	assign pmaj   = cfg.flags[lmpim_pkg::FLAG_PIX_COLUMNS] ? px : py;
	assign pmin   = cfg.flags[lmpim_pkg::FLAG_PIX_COLUMNS] ? py : px;
	assign pscale = cfg.flags[lmpim_pkg::FLAG_PIX_COLUMNS] ? cfg.panel_h : cfg.panel_w;
	assign pzig   = cfg.flags[lmpim_pkg::FLAG_PIX_ZIGZAG] && pmaj[0];
	assign pmul   = pzig ? pmaj + 7'd1 : pmaj;
	assign pbase  = {7'b0, pmul} * {7'b0, pscale};
	assign pix_full = pzig ? pbase - 14'd1 - {7'b0, pmin} : pbase + {7'b0, pmin};

	assign area_full = {7'b0, cfg.panel_w} * {7'b0, cfg.panel_h};

	// scale the panel number by the panel size and add the pixel offset
	assign tile_off = {13'b0, tline_s4} * {8'b0, area_s4};
	assign sum      = tile_off + {9'b0, pix_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		in_range_s4 <= split_s3.in_range;
		tline_s4    <= tiled ? tline_full[lmpim_pkg::TLINE_W-1:0] : '0;
		pix_s4      <= pix_full[lmpim_pkg::PIX_W-1:0];
		area_s4     <= area_full[lmpim_pkg::AREA_W-1:0];
		in_range_s5 <= in_range_s4;
		index_s5    <= in_range_s4 ? sum[lmpim_pkg::INDEX_W-1:0] : '0;
	end

	a_out_follows_s4: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> $past(valid_s4))
		else $error("result strobe without a word in the index stage");

endmodule

`default_nettype wire
